@@ sv/fpt_pkg.sv @@
// fpt_pkg: shared constants for the fault point table
// action and status codes, field widths, default table depth
// no dependencies
`default_nettype none

package fpt_pkg;

	localparam int SLOTS_DEF = 16;

	localparam int ACT_W = 3;
	localparam int DATA_W = 32;
	localparam int STAT_W = 2;

	localparam logic [ACT_W-1:0] ACT_HIT    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ARM    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DISARM = 3'd2;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

endpackage

`default_nettype wire

@@ sv/fpt_ram.sv @@
// fpt_ram: generic simple dual port ram, one write and one registered read
// width and depth set by parameters; no dependencies
`default_nettype none

module fpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ sv/fault_point_table.sv @@
// fault_point_table: associative table of fault points keyed by a 32-bit id
// depends on fpt_pkg and fpt_ram
//
// One transaction in, one transaction out. Hit, arm, disarm and query walk
// the id memory one slot per cycle from slot 0 until the first valid match
// or the last slot, then read value and count of the chosen slot and update
// it where the action calls for it. The walk is serial, as there is a single
// id memory read port and one comparator. Clear all and unused codes skip
// the walk. Valid and armed bits live in flops and reset clears them, so
// there is no clearing pass after reset. The input is not ready while a
// transaction is in work; a finished result waits in the output register
// while the next transaction is taken.
`default_nettype none

module fault_point_table #(
	parameter int SLOTS = fpt_pkg::SLOTS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [fpt_pkg::ACT_W-1:0]     action,
	input  wire logic [fpt_pkg::DATA_W-1:0]    point_id,
	input  wire logic signed [fpt_pkg::DATA_W-1:0] arm_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [fpt_pkg::DATA_W-1:0]  injected,
	output logic      [fpt_pkg::DATA_W-1:0]    count,
	output logic      [fpt_pkg::STAT_W-1:0]    status
);

	import fpt_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FETCH,
		S_EXEC
	} state_t;

	state_t state_q;

	// captured transaction
	logic [ACT_W-1:0]  act_q;
	logic [DATA_W-1:0] id_q;
	logic [DATA_W-1:0] val_q;

	// per slot flags
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] armed_q;

	// scan control
	logic [IW-1:0] scan_q;
	logic          iss_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          free_q;
	logic [IW-1:0] free_idx_q;
	logic          found_q;
	logic          alloc_ok_q;
	logic [IW-1:0] tgt_q;

	// memory ports
	logic [DATA_W-1:0] id_rd, value_rd, hits_rd;
	logic              id_rd_en, fetch_en;
	logic              id_wr_en, value_wr_en, hits_wr_en;
	logic [DATA_W-1:0] value_wr, hits_wr;

	// output register
	logic              out_free;
	logic [DATA_W-1:0] inj_n, cnt_n;
	logic [STAT_W-1:0] st_n;
	logic              set_valid, set_armed, clr_armed, clr_all, exec_go;

	// scan compare
	logic          hit_now, free_now, have_free;
	logic [IW-1:0] free_sel;

	assign in_ready = (state_q == S_IDLE);
	assign out_free = !out_valid || out_ready;
	assign exec_go  = (state_q == S_EXEC) && out_free;
	assign id_rd_en = (state_q == S_SCAN) && iss_q;
	assign fetch_en = (state_q == S_FETCH);

	assign hit_now   = cmp_vld_s1 && valid_q[cmp_idx_s1] && (id_rd == id_q);
	assign free_now  = !free_q && !valid_q[cmp_idx_s1];
	assign have_free = free_q || free_now;
	assign free_sel  = free_q ? free_idx_q : cmp_idx_s1;

	fpt_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS), .AW(IW)) u_id_ram (
		.clk     (clk),
		.wr_en   (id_wr_en),
		.wr_addr (tgt_q),
		.wr_data (id_q),
		.rd_en   (id_rd_en),
		.rd_addr (scan_q),
		.rd_data (id_rd)
	);

	fpt_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS), .AW(IW)) u_value_ram (
		.clk     (clk),
		.wr_en   (value_wr_en),
		.wr_addr (tgt_q),
		.wr_data (value_wr),
		.rd_en   (fetch_en),
		.rd_addr (tgt_q),
		.rd_data (value_rd)
	);

	fpt_ram #(.WIDTH(DATA_W), .DEPTH(SLOTS), .AW(IW)) u_hits_ram (
		.clk     (clk),
		.wr_en   (hits_wr_en),
		.wr_addr (tgt_q),
		.wr_data (hits_wr),
		.rd_en   (fetch_en),
		.rd_addr (tgt_q),
		.rd_data (hits_rd)
	);

	// action execution: result and slot updates
	always_comb begin
		inj_n       = '0;
		cnt_n       = '0;
		st_n        = ST_OK;
		set_valid   = 1'b0;
		set_armed   = 1'b0;
		clr_armed   = 1'b0;
		clr_all     = 1'b0;
		id_wr_en    = 1'b0;
		value_wr_en = 1'b0;
		hits_wr_en  = 1'b0;
		value_wr    = '0;
		hits_wr     = '0;
		case (act_q)
			ACT_HIT: begin
				if (found_q) begin
					hits_wr_en = exec_go;
					hits_wr    = hits_rd + 32'd1;
					inj_n      = armed_q[tgt_q] ? value_rd : '0;
				end else if (alloc_ok_q) begin
					set_valid   = exec_go;
					clr_armed   = exec_go;
					id_wr_en    = exec_go;
					value_wr_en = exec_go;
					hits_wr_en  = exec_go;
					hits_wr     = 32'd1;
				end else begin
					st_n = ST_FULL;
				end
			end
			ACT_ARM: begin
				if (found_q || alloc_ok_q) begin
					set_armed   = exec_go;
					value_wr_en = exec_go;
					value_wr    = val_q;
					if (!found_q) begin
						set_valid  = exec_go;
						id_wr_en   = exec_go;
						hits_wr_en = exec_go;
					end
				end else begin
					st_n = ST_FULL;
				end
			end
			ACT_DISARM: begin
				if (found_q) begin
					clr_armed = exec_go;
				end else begin
					st_n = ST_MISSING;
				end
			end
			ACT_QUERY: begin
				if (found_q) begin
					cnt_n = hits_rd;
				end else begin
					st_n = ST_MISSING;
				end
			end
			ACT_CLEAR: begin
				clr_all = exec_go;
			end
			default: begin
			end
		endcase
	end

	// sequencer, slot flags and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			act_q      <= '0;
			id_q       <= '0;
			val_q      <= '0;
			valid_q    <= '0;
			armed_q    <= '0;
			scan_q     <= '0;
			iss_q      <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			found_q    <= 1'b0;
			alloc_ok_q <= 1'b0;
			tgt_q      <= '0;
			out_valid  <= 1'b0;
			injected   <= '0;
			count      <= '0;
			status     <= ST_OK;
		end else begin
			if (out_valid && out_ready && !exec_go) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						act_q      <= action;
						id_q       <= point_id;
						val_q      <= arm_value;
						scan_q     <= '0;
						iss_q      <= 1'b1;
						cmp_vld_s1 <= 1'b0;
						free_q     <= 1'b0;
						found_q    <= 1'b0;
						alloc_ok_q <= 1'b0;
						if (action == ACT_HIT || action == ACT_ARM ||
						    action == ACT_DISARM || action == ACT_QUERY) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_SCAN: begin
					cmp_idx_s1 <= scan_q;
					if (hit_now) begin
						// first valid match ends the walk
						found_q    <= 1'b1;
						tgt_q      <= cmp_idx_s1;
						cmp_vld_s1 <= 1'b0;
						iss_q      <= 1'b0;
						state_q    <= S_FETCH;
					end else begin
						// issue one id read per cycle
						if (iss_q) begin
							if (scan_q == LAST) begin
								iss_q <= 1'b0;
							end else begin
								scan_q <= scan_q + 1'b1;
							end
						end
						// remember the lowest free slot
						if (cmp_vld_s1 && free_now) begin
							free_q     <= 1'b1;
							free_idx_q <= cmp_idx_s1;
						end
						// last slot compared without a match
						if (cmp_vld_s1 && cmp_idx_s1 == LAST) begin
							tgt_q      <= free_sel;
							alloc_ok_q <= have_free;
							cmp_vld_s1 <= 1'b0;
							state_q    <= S_FETCH;
						end else begin
							cmp_vld_s1 <= iss_q;
						end
					end
				end
				S_FETCH: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						out_valid <= 1'b1;
						injected  <= inj_n;
						count     <= cnt_n;
						status    <= st_n;
						state_q   <= S_IDLE;
						if (clr_all) begin
							valid_q <= '0;
							armed_q <= '0;
						end
						if (set_valid) begin
							valid_q[tgt_q] <= 1'b1;
						end
						if (set_armed) begin
							armed_q[tgt_q] <= 1'b1;
						end
						if (clr_armed) begin
							armed_q[tgt_q] <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
